/* rtl/hpa_pkg.sv */
// hpa_pkg: shared types, constants and ring index helper for the helicity
// pattern asymmetry block. Depends on nothing; used by every rtl file.
`default_nettype none

package hpa_pkg;

  // ring of per-window increments and helicity
  localparam int RING_DEPTH = 24;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int RING_XW    = RING_AW + 2;

  // pattern sums, their products and the asymmetry numerator/denominator
  localparam int SUM_W     = 40;
  localparam int PROD_W    = 2 * SUM_W;
  localparam int NUM_W     = PROD_W + 2;
  localparam int DIGIT_W   = 8;
  localparam int MUL_STEPS = SUM_W / DIGIT_W;
  localparam int Q_BITS    = 15;

  // configuration register indexes
  localparam logic [2:0] CFG_PATTERN_LENGTH = 3'd0;
  localparam logic [2:0] CFG_HELICITY_DELAY = 3'd1;
  localparam logic [2:0] CFG_SKIP_CYCLES    = 3'd2;
  localparam logic [2:0] CFG_MIN_BEAM       = 3'd3;

  // helicity codes: bit 1 valid, bit 0 helicity
  localparam logic [1:0] HEL_INVALID = 2'b00;
  localparam logic [1:0] HEL_ZERO    = 2'b10;
  localparam logic [1:0] HEL_ONE     = 2'b11;

  typedef struct packed {
    logic        cycle_start;
    logic        trig_helicity;
    logic [31:0] coinc_scaler;
    logic [31:0] accid_scaler;
    logic [31:0] bcm_scaler;
    logic [31:0] hel_scaler;
  } item_t;

  typedef struct packed {
    logic               asym_valid;
    logic signed [15:0] asym_uncorrected;
    logic signed [15:0] asym_corrected;
    logic               divide_fault;
    logic               err_incomplete_cycle;
    logic               err_helicity_mismatch;
    logic               err_low_beam;
  } result_t;

  // one classified window, handed from front to back
  typedef struct packed {
    logic               do_sum;
    logic [4:0]         plen;
    logic [RING_AW-1:0] sum_start;
    logic [RING_AW-1:0] wr_idx;
    logic [RING_AW-1:0] hel_idx;
    logic [1:0]         hstate;
    logic [31:0]        coinc_inc;
    logic [31:0]        accid_inc;
    logic [31:0]        charge_inc;
    logic               e_inc;
    logic               e_mis;
    logic               e_low;
  } cmd_t;

  // reduce a value below three ring depths to a ring index
  function automatic logic [RING_AW-1:0] ring_wrap(input logic [RING_XW-1:0] v);
    logic [RING_XW-1:0] r;
    if (v >= RING_XW'(2 * RING_DEPTH)) begin
      r = v - RING_XW'(2 * RING_DEPTH);
    end else if (v >= RING_XW'(RING_DEPTH)) begin
      r = v - RING_XW'(RING_DEPTH);
    end else begin
      r = v;
    end
    return r[RING_AW-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/helicity_pattern_asymmetry.sv */
// helicity_pattern_asymmetry: top level joining front, command queue and back.
// Depends on hpa_pkg, hpa_front, hpa_queue and hpa_back.
//
//  channel   handshake        payload
//  input     push / full      item   (hpa_pkg::item_t)
//  result    pop / empty      result (hpa_pkg::result_t)
//  config    wr_en            wr_index, wr_data
//
// A window without a pattern sum goes from idle straight to the result stage
// in the back end; one with a sum passes through the ring walk, the
// digit-serial multiplier (four products) and the 15-step divider.
// The front takes a window every cycle until the two-entry queue fills.
// Reset is synchronous; all rings come up invalid, no clearing pass.
// A held result stalls the back end, which in turn stalls the queue.
`default_nettype none

module helicity_pattern_asymmetry (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire hpa_pkg::item_t   item,
  output logic                  empty,
  input  wire logic             pop,
  output hpa_pkg::result_t      result,
  input  wire logic             wr_en,
  input  wire logic [2:0]       wr_index,
  input  wire logic [15:0]      wr_data
);

  hpa_pkg::cmd_t cmd_in;
  hpa_pkg::cmd_t cmd_out;
  logic          cmd_push;
  logic          q_empty;
  logic          q_pop;

  hpa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .q_full   (full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  hpa_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_data (cmd_in),
    .full    (full),
    .rd      (q_pop),
    .q_empty (q_empty),
    .rd_data (cmd_out)
  );

  hpa_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (cmd_out),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire

/* rtl/hpa_queue.sv */
// hpa_queue: two-entry command queue between front and back.
// Depends on hpa_pkg for cmd_t.
`default_nettype none

module hpa_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire hpa_pkg::cmd_t wr_data,
  output logic               full,
  input  wire logic          rd,
  output logic               q_empty,
  output hpa_pkg::cmd_t      rd_data
);

  hpa_pkg::cmd_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd && !q_empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, (wr && !full)} - {1'b0, (rd && !q_empty)};
    end
  end

endmodule

`default_nettype wire

/* rtl/hpa_front.sv */
// hpa_front: configuration registers, increments, error checks and pattern
// bookkeeping for each window. Depends on hpa_pkg.
`default_nettype none

module hpa_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire hpa_pkg::item_t item,
  input  wire logic           q_full,
  output logic                cmd_push,
  output hpa_pkg::cmd_t       cmd,
  input  wire logic           wr_en,
  input  wire logic [2:0]     wr_index,
  input  wire logic [15:0]    wr_data
);

  localparam logic [5:0]        FLIP_SAT   = 6'd62;
  localparam logic [5:0]        FLIP_RESET = 6'd63;
  localparam logic signed [5:0] GOOD_MAX   = 6'sd31;
  localparam logic signed [5:0] GOOD_RESET = -6'sd3;

  logic [4:0]  pattern_length;
  logic [4:0]  helicity_delay;
  logic [3:0]  skip_cycles;
  logic [15:0] min_beam_increment;

  logic [31:0] last_coinc;
  logic [31:0] last_accid;
  logic [31:0] last_charge;
  logic [31:0] last_hel_count;
  logic [hpa_pkg::RING_AW-1:0] window_index;
  logic        first_window;
  logic [5:0]  flip_count;
  logic signed [5:0] good_patterns;

  logic [hpa_pkg::RING_AW-1:0] w;
  logic [hpa_pkg::RING_AW-1:0] dm;
  logic [hpa_pkg::RING_AW-1:0] pm;
  logic [hpa_pkg::RING_AW-1:0] hidx;
  logic [5:0]  flip_count_next;
  logic signed [5:0] good_patterns_next;
  logic signed [5:0] neg_skip;
  logic signed [5:0] gp_a;
  logic        do_sum;
  logic        e_inc;
  logic        e_low;
  logic        e_mis;
  logic [31:0] beam;
  logic [31:0] dh;
  logic [1:0]  hstate;
  logic        accept;

  assign accept   = push && !q_full;
  assign cmd_push = accept;

  // ring positions for this window
  assign w  = (window_index == hpa_pkg::RING_AW'(hpa_pkg::RING_DEPTH - 1)) ? '0
            : window_index + 1'b1;
  assign dm = hpa_pkg::ring_wrap(hpa_pkg::RING_XW'(helicity_delay));
  assign pm = hpa_pkg::ring_wrap(hpa_pkg::RING_XW'(pattern_length));
  assign hidx = hpa_pkg::ring_wrap(hpa_pkg::RING_XW'(w)
              + hpa_pkg::RING_XW'(hpa_pkg::RING_DEPTH - 1) - hpa_pkg::RING_XW'(dm));

  // pattern length check and good pattern count
  assign neg_skip = 6'sd0 - $signed({2'b00, skip_cycles});

  always_comb begin
    flip_count_next = (flip_count == FLIP_SAT) ? flip_count : flip_count + 6'd1;
    gp_a  = good_patterns;
    e_inc = 1'b0;
    if (item.cycle_start) begin
      if (gp_a < GOOD_MAX) begin
        gp_a = gp_a + 6'sd1;
      end
      if (flip_count_next != {1'b0, pattern_length}) begin
        gp_a  = neg_skip;
        e_inc = 1'b1;
      end
      flip_count_next = '0;
    end
    do_sum = gp_a > $signed({2'b00, skip_cycles});
    good_patterns_next = do_sum ? gp_a - 6'sd1 : gp_a;
    if (e_low || e_mis) begin
      good_patterns_next = neg_skip;
    end
  end

  // beam level
  assign beam  = item.bcm_scaler - last_charge;
  assign e_low = !($signed(beam) > $signed({16'b0, min_beam_increment}));

  // scaler helicity against trigger helicity
  assign dh = item.hel_scaler - last_hel_count;
  always_comb begin
    if (dh == '0) begin
      hstate = hpa_pkg::HEL_ZERO;
    end else if (!dh[31]) begin
      hstate = hpa_pkg::HEL_ONE;
    end else begin
      hstate = hpa_pkg::HEL_INVALID;
    end
  end
  assign e_mis = !first_window && (!hstate[1] || (hstate[0] != item.trig_helicity));

  // command to the back end
  always_comb begin
    cmd.do_sum     = do_sum;
    cmd.plen       = pattern_length;
    cmd.sum_start  = hpa_pkg::ring_wrap(hpa_pkg::RING_XW'(hidx)
                   + hpa_pkg::RING_XW'(hpa_pkg::RING_DEPTH + 1) - hpa_pkg::RING_XW'(pm));
    cmd.wr_idx     = w;
    cmd.hel_idx    = hpa_pkg::ring_wrap(hpa_pkg::RING_XW'(w)
                   + hpa_pkg::RING_XW'(hpa_pkg::RING_DEPTH) - hpa_pkg::RING_XW'(dm));
    cmd.hstate     = hstate;
    cmd.coinc_inc  = item.coinc_scaler - last_coinc;
    cmd.accid_inc  = item.accid_scaler - last_accid;
    cmd.charge_inc = e_low ? '0 : beam;
    cmd.e_inc      = e_inc;
    cmd.e_mis      = e_mis;
    cmd.e_low      = e_low;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= 5'd4;
      helicity_delay     <= 5'd0;
      skip_cycles        <= 4'd3;
      min_beam_increment <= 16'd10;
    end else if (wr_en) begin
      unique case (wr_index)
        hpa_pkg::CFG_PATTERN_LENGTH: pattern_length     <= wr_data[4:0];
        hpa_pkg::CFG_HELICITY_DELAY: helicity_delay     <= wr_data[4:0];
        hpa_pkg::CFG_SKIP_CYCLES:    skip_cycles        <= wr_data[3:0];
        hpa_pkg::CFG_MIN_BEAM:       min_beam_increment <= wr_data;
        default: ;
      endcase
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_coinc     <= '0;
      last_accid     <= '0;
      last_charge    <= '0;
      last_hel_count <= '0;
      window_index   <= hpa_pkg::RING_AW'(hpa_pkg::RING_DEPTH - 1);
      first_window   <= 1'b1;
      flip_count     <= FLIP_RESET;
      good_patterns  <= GOOD_RESET;
    end else if (accept) begin
      last_coinc     <= item.coinc_scaler;
      last_accid     <= item.accid_scaler;
      last_charge    <= item.bcm_scaler;
      last_hel_count <= item.hel_scaler;
      window_index   <= w;
      first_window   <= 1'b0;
      flip_count     <= flip_count_next;
      good_patterns  <= good_patterns_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/hpa_back.sv */
// hpa_back: increment rings, pattern sums, serial multiply, restoring divide
// and the result register. Depends on hpa_pkg.
`default_nettype none

module hpa_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire hpa_pkg::cmd_t q_data,
  output logic               q_pop,
  output logic               empty,
  input  wire logic          pop,
  output hpa_pkg::result_t   result
);

  localparam int SW = hpa_pkg::SUM_W;
  localparam int PW = hpa_pkg::PROD_W;
  localparam int NW = hpa_pkg::NUM_W;
  localparam int AW = hpa_pkg::RING_AW;
  localparam logic signed [15:0] Q_MAX = 16'sh7FFF;
  localparam logic signed [15:0] Q_MIN = 16'sh8000;

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_MLOAD, S_MUL, S_MSTORE, S_DPREP, S_DMAG, S_DCMP,
    S_DIV, S_DSIGN, S_ANEXT, S_DONE
  } state_t;

  function automatic logic [SW-1:0] mag_sum(input logic signed [SW-1:0] v);
    return v[SW-1] ? SW'(-v) : v;
  endfunction

  state_t state;
  hpa_pkg::cmd_t cur;
  logic [4:0]    cnt;
  logic [AW-1:0] idx;
  logic signed [SW-1:0] su0, su1, sc0, sc1, sb0, sb1;
  logic          asel, psel;
  logic [SW-1:0] mag_a, bsh;
  logic          mneg;
  logic [PW-1:0] acc;
  logic signed [PW:0] pa, pc;
  logic signed [NW-1:0] num, den;
  logic [NW-1:0] nmag, dmag;
  logic          rneg;
  logic [NW:0]   rem;
  logic [hpa_pkg::Q_BITS-1:0] q;
  logic signed [15:0] res, au, ac;
  logic          fault;

  logic [1:0]    hel_ring [hpa_pkg::RING_DEPTH];
  logic [31:0]   coinc_ring [hpa_pkg::RING_DEPTH];
  logic [31:0]   accid_ring [hpa_pkg::RING_DEPTH];
  logic [31:0]   charge_ring [hpa_pkg::RING_DEPTH];
  logic [hpa_pkg::RING_DEPTH-1:0] inc_valid;

  logic [1:0]    rd_hel;
  logic [31:0]   rd_coinc, rd_accid, rd_charge;
  logic signed [SW-1:0] x_coinc, x_corr, x_charge;
  logic signed [SW-1:0] op_a, op_b, u0, u1;
  logic [PW-1:0] acc_next;
  logic [NW:0]   rem2;
  logic          out_load;

  // ring read for the sum walk; entries never written read as minus one
  assign rd_hel    = hel_ring[idx];
  assign rd_coinc  = inc_valid[idx] ? coinc_ring[idx] : '1;
  assign rd_accid  = inc_valid[idx] ? accid_ring[idx] : '1;
  assign rd_charge = inc_valid[idx] ? charge_ring[idx] : '1;
  assign x_coinc   = SW'($signed(rd_coinc));
  assign x_corr    = SW'($signed(rd_coinc)) - SW'($signed(rd_accid));
  assign x_charge  = SW'($signed(rd_charge));

  // multiplier operands for the current asymmetry and product
  assign u0   = asel ? sc0 : su0;
  assign u1   = asel ? sc1 : su1;
  assign op_a = psel ? u1 : u0;
  assign op_b = psel ? sb0 : sb1;

  // one digit of the shift-add multiply, top digit first
  assign acc_next = {acc[PW-hpa_pkg::DIGIT_W-1:0], {hpa_pkg::DIGIT_W{1'b0}}}
                  + PW'({{hpa_pkg::DIGIT_W{1'b0}}, mag_a}
                        * bsh[SW-1 -: hpa_pkg::DIGIT_W]);

  // one restoring divide step
  assign rem2 = {rem[NW-1:0], 1'b0};

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign out_load = (state == S_DONE) && (empty || pop);

  // sequencer, datapath registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      empty  <= 1'b1;
      cnt    <= '0;
      asel   <= 1'b0;
      psel   <= 1'b0;
      fault  <= 1'b0;
      result <= '0;
    end else begin
      if (out_load) begin
        empty <= 1'b0;
      end else if (pop && !empty) begin
        empty <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur   <= q_data;
            idx   <= q_data.sum_start;
            cnt   <= '0;
            su0 <= '0; su1 <= '0; sc0 <= '0; sc1 <= '0; sb0 <= '0; sb1 <= '0;
            au    <= '0;
            ac    <= '0;
            fault <= 1'b0;
            asel  <= 1'b0;
            psel  <= 1'b0;
            state <= q_data.do_sum ? S_SUM : S_DONE;
          end
        end
        S_SUM: begin
          if (cnt == cur.plen) begin
            state <= S_MLOAD;
          end else begin
            if (rd_hel[1]) begin
              if (rd_hel[0]) begin
                su1 <= su1 + x_coinc; sc1 <= sc1 + x_corr; sb1 <= sb1 + x_charge;
              end else begin
                su0 <= su0 + x_coinc; sc0 <= sc0 + x_corr; sb0 <= sb0 + x_charge;
              end
            end
            idx <= (idx == AW'(hpa_pkg::RING_DEPTH - 1)) ? '0 : idx + 1'b1;
            cnt <= cnt + 5'd1;
          end
        end
        S_MLOAD: begin
          mag_a <= mag_sum(op_a);
          bsh   <= mag_sum(op_b);
          mneg  <= op_a[SW-1] ^ op_b[SW-1];
          acc   <= '0;
          cnt   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          acc <= acc_next;
          bsh <= {bsh[SW-hpa_pkg::DIGIT_W-1:0], {hpa_pkg::DIGIT_W{1'b0}}};
          cnt <= cnt + 5'd1;
          if (cnt == 5'(hpa_pkg::MUL_STEPS - 1)) begin
            state <= S_MSTORE;
          end
        end
        S_MSTORE: begin
          if (!psel) begin
            pa    <= mneg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
            psel  <= 1'b1;
            state <= S_MLOAD;
          end else begin
            pc    <= mneg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
            state <= S_DPREP;
          end
        end
        S_DPREP: begin
          num   <= NW'(pa) - NW'(pc);
          den   <= NW'(pa) + NW'(pc);
          state <= S_DMAG;
        end
        S_DMAG: begin
          nmag  <= num[NW-1] ? NW'(-num) : num;
          dmag  <= den[NW-1] ? NW'(-den) : den;
          rneg  <= num[NW-1] ^ den[NW-1];
          state <= S_DCMP;
        end
        S_DCMP: begin
          if (dmag == '0) begin
            fault <= 1'b1;
            res   <= '0;
            state <= S_ANEXT;
          end else if (nmag == '0) begin
            res   <= '0;
            state <= S_ANEXT;
          end else if (nmag >= dmag) begin
            res   <= rneg ? Q_MIN : Q_MAX;
            state <= S_ANEXT;
          end else begin
            rem   <= {1'b0, nmag};
            q     <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem2 >= {1'b0, dmag}) begin
            rem <= rem2 - {1'b0, dmag};
            q   <= {q[hpa_pkg::Q_BITS-2:0], 1'b1};
          end else begin
            rem <= rem2;
            q   <= {q[hpa_pkg::Q_BITS-2:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(hpa_pkg::Q_BITS - 1)) begin
            state <= S_DSIGN;
          end
        end
        S_DSIGN: begin
          res   <= rneg ? -$signed({1'b0, q}) : $signed({1'b0, q});
          state <= S_ANEXT;
        end
        S_ANEXT: begin
          if (!asel) begin
            au    <= res;
            asel  <= 1'b1;
            psel  <= 1'b0;
            state <= S_MLOAD;
          end else begin
            ac    <= res;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            result.asym_valid            <= cur.do_sum;
            result.asym_uncorrected      <= au;
            result.asym_corrected        <= ac;
            result.divide_fault          <= fault;
            result.err_incomplete_cycle  <= cur.e_inc;
            result.err_helicity_mismatch <= cur.e_mis;
            result.err_low_beam          <= cur.e_low;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ring contents, written once the window is finished
  always_ff @(posedge clk) begin
    if (out_load) begin
      coinc_ring[cur.wr_idx]  <= cur.coinc_inc;
      accid_ring[cur.wr_idx]  <= cur.accid_inc;
      charge_ring[cur.wr_idx] <= cur.charge_inc;
    end
  end

  // helicity ring and increment valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hpa_pkg::RING_DEPTH; i++) begin
        hel_ring[i] <= hpa_pkg::HEL_INVALID;
      end
      inc_valid <= '0;
    end else if (out_load) begin
      hel_ring[cur.hel_idx]  <= cur.hstate;
      inc_valid[cur.wr_idx]  <= 1'b1;
    end
  end

  // sum walk never passes the pattern length
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SUM |-> cnt <= cur.plen)
    else $error("sum walk overran pattern length");

  // divide remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < {1'b0, dmag})
    else $error("divide remainder out of range");

  // a finished window waits while the result register is held
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !empty && !pop) |=> state == S_DONE)
    else $error("result overwritten before transfer");

endmodule

`default_nettype wire
